### hdl/rrfw_pkg.sv
// ----------------------------------------------------------------------------
// rrfw_pkg
// Shared types and constants of the rotated RGB frame store writer.
// ----------------------------------------------------------------------------
package rrfw_pkg;

	// Operation codes carried in the operation field
	typedef enum logic [1:0] {
		OP_DRAW = 2'd0,
		OP_SET  = 2'd1,
		OP_FILL = 2'd2,
		OP_READ = 2'd3
	} op_e;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam logic CFG_IDX_ROTATION = 1'b0;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        color565;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       clipped;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic ram_we;       // write the frame store
		logic ram_re;       // read the frame store at the pixel address
		logic sweep;        // address and data from the sweep counter
		logic sweep_zero;   // sweep writes zero (clearing pass)
		logic cnt_clr;      // restart the sweep counter
		logic cnt_inc;      // advance the sweep counter
		logic fill_latch;   // capture the expanded fill colour
		logic out_load;     // load the result register
		logic out_from_ram; // result takes the read data
		logic out_clip;     // clipped flag for a result not from the store
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_e  op;
		logic clip;
		logic sweep_last;
	} sts_t;

	// RGB565 to RGB888 by bit replication
	function automatic logic [23:0] widen565(input logic [15:0] c);
		return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
	endfunction

endpackage

### hdl/rrfw_ram.sv
// ----------------------------------------------------------------------------
// rrfw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rrfw_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/rrfw_dp.sv
// ----------------------------------------------------------------------------
// rrfw_dp
// Datapath: clipping, rotation mapping, sweep counter, frame store, result.
// ----------------------------------------------------------------------------
module rrfw_dp #(
	parameter int PANEL_WIDTH  = 64,
	parameter int PANEL_HEIGHT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrfw_pkg::in_item_t  pix_data,
	input  logic [1:0]          rotation,
	input  rrfw_pkg::cmd_t      cmd,
	output rrfw_pkg::sts_t      sts,
	output rrfw_pkg::out_item_t res_data
);

	localparam int PIXELS = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int AW     = $clog2(PIXELS);
	localparam int XW     = $clog2(PANEL_WIDTH);
	localparam int YW     = $clog2(PANEL_HEIGHT);
	localparam int MAXD   = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int CW     = $clog2(MAXD);
	localparam logic [CW:0] W_M1 = (CW+1)'(PANEL_WIDTH - 1);
	localparam logic [CW:0] H_M1 = (CW+1)'(PANEL_HEIGHT - 1);
	localparam logic [15:0] W16  = 16'(PANEL_WIDTH);
	localparam logic [15:0] H16  = 16'(PANEL_HEIGHT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

	logic [15:0]    x_u, y_u;
	logic [15:0]    lw, lh;
	logic           x_pos, y_pos;
	logic           log_in, phys_in;
	logic [CW:0]    lx, ly;
	logic [CW:0]    px_l, py_l;
	logic [XW-1:0]  px;
	logic [YW-1:0]  py;
	logic [AW-1:0]  pix_addr;
	logic [AW-1:0]  cnt_q;
	logic [23:0]    fill_q;
	logic [23:0]    pix_wdata;
	logic [23:0]    ram_wdata;
	logic [AW-1:0]  ram_waddr;
	logic [23:0]    ram_rdata;
	rrfw_pkg::op_e  op;

	assign op    = rrfw_pkg::op_e'(pix_data.operation);
	assign x_u   = pix_data.pos_x;
	assign y_u   = pix_data.pos_y;
	assign x_pos = ~x_u[15];
	assign y_pos = ~y_u[15];

	// Logical bounds swap on odd quarter turns
	assign lw = rotation[0] ? H16 : W16;
	assign lh = rotation[0] ? W16 : H16;

	assign log_in  = x_pos && y_pos && (x_u < lw) && (y_u < lh);
	assign phys_in = x_pos && y_pos && (x_u < W16) && (y_u < H16);

	assign lx = {1'b0, x_u[CW-1:0]};
	assign ly = {1'b0, y_u[CW-1:0]};

	always_comb begin
		if (op == rrfw_pkg::OP_READ) begin
			px_l = lx;
			py_l = ly;
		end else begin
			unique case (rotation)
				2'd1: begin
					px_l = W_M1 - ly;
					py_l = lx;
				end
				2'd2: begin
					px_l = W_M1 - lx;
					py_l = H_M1 - ly;
				end
				2'd3: begin
					px_l = ly;
					py_l = H_M1 - lx;
				end
				default: begin
					px_l = lx;
					py_l = ly;
				end
			endcase
		end
	end

	assign px       = px_l[XW-1:0];
	assign py       = py_l[YW-1:0];
	assign pix_addr = AW'(py) * AW'(PANEL_WIDTH) + AW'(px);

	assign sts.op         = op;
	assign sts.clip       = (op == rrfw_pkg::OP_READ) ? ~phys_in : ~log_in;
	assign sts.sweep_last = (cnt_q == LAST_ADDR);

	assign pix_wdata = (op == rrfw_pkg::OP_SET) ?
		{pix_data.red_in, pix_data.green_in, pix_data.blue_in} :
		rrfw_pkg::widen565(pix_data.color565);

	assign ram_waddr = cmd.sweep ? cnt_q : pix_addr;
	assign ram_wdata = cmd.sweep ? (cmd.sweep_zero ? 24'd0 : fill_q) : pix_wdata;

	// Sweep counter for the clearing pass and fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_latch) begin
			fill_q <= rrfw_pkg::widen565(pix_data.color565);
		end
		if (cmd.out_load) begin
			if (cmd.out_from_ram) begin
				res_data <= {ram_rdata, 1'b0};
			end else begin
				res_data <= {24'd0, cmd.out_clip};
			end
		end
	end

	rrfw_ram #(
		.DATA_W (24),
		.DEPTH  (PIXELS)
	) u_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_re),
		.raddr (pix_addr),
		.rdata (ram_rdata)
	);

endmodule

### hdl/rrfw_ctrl.sv
// ----------------------------------------------------------------------------
// rrfw_ctrl
// Controller: sequences clearing pass, pixel operations, reads and fills.
// ----------------------------------------------------------------------------
module rrfw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	output logic           res_valid,
	input  logic           res_stall,
	input  rrfw_pkg::sts_t sts,
	output rrfw_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FILL
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   slot_free;
	logic   accept;

	// Result slot is free at this edge if empty or being drained
	assign slot_free = ~res_valid_q | ~res_stall;
	assign pix_stall = ~((state_q == ST_IDLE) && slot_free);
	assign accept    = pix_valid & ~pix_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.ram_we     = 1'b1;
				cmd.sweep      = 1'b1;
				cmd.sweep_zero = 1'b1;
				cmd.cnt_inc    = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (sts.op)
						rrfw_pkg::OP_DRAW, rrfw_pkg::OP_SET: begin
							cmd.ram_we   = ~sts.clip;
							cmd.out_load = 1'b1;
							cmd.out_clip = sts.clip;
						end
						rrfw_pkg::OP_READ: begin
							if (sts.clip) begin
								cmd.out_load = 1'b1;
								cmd.out_clip = 1'b1;
							end else begin
								cmd.ram_re = 1'b1;
								state_d    = ST_READ;
							end
						end
						rrfw_pkg::OP_FILL: begin
							cmd.fill_latch = 1'b1;
							cmd.cnt_clr    = 1'b1;
							state_d        = ST_FILL;
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.out_load     = 1'b1;
				cmd.out_from_ram = 1'b1;
				state_d          = ST_IDLE;
			end
			ST_FILL: begin
				cmd.ram_we  = 1'b1;
				cmd.sweep   = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.sweep_last) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (~res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// An unclipped read waits in the read state for the store, result slot empty
	a_read_wait: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (sts.op == rrfw_pkg::OP_READ) && !sts.clip
		|=> (state_q == ST_READ) && !res_valid_q)
		else $error("read did not enter wait state with empty result slot");

	// Never overwrite a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(res_valid_q && res_stall))
		else $error("result register overwritten while stalled");

	// Sweep writes only during the clearing pass or a fill
	a_sweep_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_we && cmd.sweep |-> (state_q == ST_CLEAR) || (state_q == ST_FILL))
		else $error("sweep write outside clear or fill");

	// No store write while a read is in flight
	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !cmd.ram_we)
		else $error("store written during read");

endmodule

### hdl/rotated_rgb_framebuffer_writer_unit.sv
// ----------------------------------------------------------------------------
// rotated_rgb_framebuffer_writer_unit
// RGB888 frame store: RGB565 draw and raw set in rotated coords, fill, read.
// ----------------------------------------------------------------------------
// Draw, set and clipped read results appear the cycle after transfer;
//   an unclipped read result passes the registered store read port first.
// Throughput: one draw or set per cycle while the result slot is free; a read
//   holds off new items until its result loads; a fill occupies the single
//   store write port over every pixel. Reset: rotation returns to 0 and a
//   clearing pass writes zero to every pixel, during which no item is taken.
// ----------------------------------------------------------------------------
module rotated_rgb_framebuffer_writer_unit #(
	parameter int PANEL_WIDTH  = 64,
	parameter int PANEL_HEIGHT = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel operations in
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  rrfw_pkg::in_item_t           pix_data,
	// results out
	output logic                         res_valid,
	input  logic                         res_stall,
	output rrfw_pkg::out_item_t          res_data,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrfw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [1:0]     rotation_q;
	logic           cfg_write;
	rrfw_pkg::cmd_t cmd;
	rrfw_pkg::sts_t sts;

	// Configuration: a single rotation register at byte address zero.
	// The register decode looks at the word index only; pready is tied high
	// so every access completes in its access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_write && (paddr[2] == rrfw_pkg::CFG_IDX_ROTATION)) begin
			rotation_q <= pwdata[1:0];
		end
	end

	// Read back the rotation; other addresses return zero
	assign prdata = (paddr[2] == rrfw_pkg::CFG_IDX_ROTATION) ? {30'd0, rotation_q} : 32'd0;

	// Controller: owns the state machine, the input stall and the result valid.
	// It hands per-cycle commands to the datapath and takes back the decoded
	// operation, the clip verdict and the end of a sweep.
	rrfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: clips and rotates coordinates, forms the row-major physical
	// address, drives the frame store and holds the result register.
	rrfw_dp #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_data (pix_data),
		.rotation (rotation_q),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (res_data)
	);

endmodule

### sim/rotated_rgb_framebuffer_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rgb_framebuffer_writer_checker
// Watches both pixel channels and the register port, predicts every result
// from a shadow frame store and compares it field by field.
// ----------------------------------------------------------------------------
module rotated_rgb_framebuffer_writer_checker #(
	parameter int PANEL_W = 64,
	parameter int PANEL_H = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	input  logic                         pix_stall,
	input  rrfw_pkg::in_item_t           pix_data,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  rrfw_pkg::out_item_t          res_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrfw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           outstanding,
	output int                           checked
);

	localparam int PIXELS = PANEL_W * PANEL_H;
	localparam logic [rrfw_pkg::PADDR_W-1:0] ROT_ADDR =
		rrfw_pkg::PADDR_W'(4 * int'(rrfw_pkg::CFG_IDX_ROTATION));

	logic [23:0]         shadow_store [PIXELS];
	logic [1:0]          rot_shadow;
	rrfw_pkg::out_item_t awaited_results [$];

	// RGB565 to RGB888, top bits of each channel repeated into the low bits
	function automatic logic [23:0] expand565(input logic [15:0] c);
		logic [7:0] r, g, b;
		r = {c[15:11], 3'b000} | {5'b00000, c[15:13]};
		g = {c[10:5], 2'b00} | {6'b000000, c[10:9]};
		b = {c[4:0], 3'b000} | {5'b00000, c[4:2]};
		return {r, g, b};
	endfunction

	// Update the shadow store for one transfer and return the result it causes
	function automatic rrfw_pkg::out_item_t apply_pixel_op(input rrfw_pkg::in_item_t it);
		rrfw_pkg::out_item_t res;
		int x, y, lw, lh, px, py;
		logic [23:0] v;
		res = '0;
		x = int'(it.pos_x);
		y = int'(it.pos_y);
		lw = rot_shadow[0] ? PANEL_H : PANEL_W;
		lh = rot_shadow[0] ? PANEL_W : PANEL_H;
		unique case (rrfw_pkg::op_e'(it.operation))
			rrfw_pkg::OP_DRAW, rrfw_pkg::OP_SET: begin
				if (x < 0 || y < 0 || x >= lw || y >= lh) begin
					res.clipped = 1'b1;
				end else begin
					unique case (rot_shadow)
						2'd1: begin px = PANEL_W - 1 - y; py = x; end
						2'd2: begin px = PANEL_W - 1 - x; py = PANEL_H - 1 - y; end
						2'd3: begin px = y; py = PANEL_H - 1 - x; end
						default: begin px = x; py = y; end
					endcase
					v = (rrfw_pkg::op_e'(it.operation) == rrfw_pkg::OP_DRAW) ?
						expand565(it.color565) : {it.red_in, it.green_in, it.blue_in};
					shadow_store[py * PANEL_W + px] = v;
				end
			end
			rrfw_pkg::OP_FILL: begin
				v = expand565(it.color565);
				foreach (shadow_store[i]) shadow_store[i] = v;
			end
			default: begin
				if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_H)
					res.clipped = 1'b1;
				else
					{res.red_out, res.green_out, res.blue_out} = shadow_store[y * PANEL_W + x];
			end
		endcase
		return res;
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rrfw_pkg::out_item_t want;
		if (!arst_n) begin
			rot_shadow = '0;
			foreach (shadow_store[i]) shadow_store[i] = '0;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			// register port: track writes, check read-back
			if (psel && penable && pready && paddr == ROT_ADDR) begin
				if (pwrite)
					rot_shadow = pwdata[1:0];
				else if (prdata !== 32'(rot_shadow))
					flag("rotation read-back", 32'(rot_shadow), prdata);
			end
			// results first: a result never belongs to a transfer of the same edge
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, expected none, got 0x%0h",
					         $time, res_data);
				end else begin
					want = awaited_results.pop_front();
					outstanding--;
					checked++;
					if (res_data.red_out !== want.red_out)
						flag("red_out", 32'(want.red_out), 32'(res_data.red_out));
					if (res_data.green_out !== want.green_out)
						flag("green_out", 32'(want.green_out), 32'(res_data.green_out));
					if (res_data.blue_out !== want.blue_out)
						flag("blue_out", 32'(want.blue_out), 32'(res_data.blue_out));
					if (res_data.clipped !== want.clipped)
						flag("clipped", 32'(want.clipped), 32'(res_data.clipped));
				end
			end
			if (pix_valid && !pix_stall) begin
				awaited_results.push_back(apply_pixel_op(pix_data));
				outstanding++;
			end
		end
	end

endmodule

### sim/rotated_rgb_framebuffer_writer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rgb_framebuffer_writer_unit_tb
// Drives draw, set, fill and read transfers through every rotation, with
// random gaps and back-pressure; the checker beside the block does the rest.
// ----------------------------------------------------------------------------
module rotated_rgb_framebuffer_writer_unit_tb;

	localparam int PANEL_W = 64;
	localparam int PANEL_H = 32;
	localparam int PIXELS = PANEL_W * PANEL_H;
	localparam logic [rrfw_pkg::PADDR_W-1:0] ROT_ADDR =
		rrfw_pkg::PADDR_W'(4 * int'(rrfw_pkg::CFG_IDX_ROTATION));
	// Random transfers per rotation phase; eight phases plus the opening set
	localparam int PHASE_ITEMS = 141;
	localparam int PHASES = 8;
	localparam logic [1:0] ROT_PLAN [PHASES] = '{2'd1, 2'd3, 2'd2, 2'd0,
	                                             2'd3, 2'd1, 2'd2, 2'd0};
	// A fill or the reset clearing pass keeps the block busy for a whole frame
	localparam int SETTLE = PIXELS + 16;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN = 32;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         pix_valid = 1'b0;
	logic                         pix_stall;
	rrfw_pkg::in_item_t           pix_data = '0;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	rrfw_pkg::out_item_t          res_data;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [rrfw_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	int fail_count, outstanding, checked;
	int ops_sent [4];
	logic [1:0] rot_now;
	int res_hold;

	rotated_rgb_framebuffer_writer_unit #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_data (pix_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rotated_rgb_framebuffer_writer_checker #(
		.PANEL_W(PANEL_W),
		.PANEL_H(PANEL_H)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result back-pressure: mostly short stalls, a few long ones, and calm
	// stretches in which every result is taken at once
	always @(posedge clk) begin : result_pressure
		int r;
		if (res_hold != 0) begin
			res_hold <= res_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				res_stall <= 1'b1;
				res_hold <= $urandom_range(0, 2);
			end else if (r < 24) begin
				res_stall <= 1'b1;
				res_hold <= $urandom_range(10, 40);
			end else if (r < 30) begin
				res_stall <= 1'b0;
				res_hold <= $urandom_range(50, 200);
			end else begin
				res_stall <= 1'b0;
				res_hold <= $urandom_range(0, 3);
			end
		end
	end

	// Watchdog: end the run once nothing has moved on any port for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic rrfw_pkg::in_item_t pixel_op(input rrfw_pkg::op_e op, input int x,
	                                                input int y, input logic [15:0] c,
	                                                input logic [23:0] rgb);
		rrfw_pkg::in_item_t it;
		it.operation = op;
		it.pos_x = 16'(x);
		it.pos_y = 16'(y);
		it.color565 = c;
		{it.red_in, it.green_in, it.blue_in} = rgb;
		return it;
	endfunction

	// Coordinate mostly inside the span, sometimes just past either edge,
	// now and then anywhere in the 16-bit range
	function automatic logic [15:0] pick_coord(input int span);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 78) return 16'($urandom_range(0, span - 1));
		if (sel < 86) return 16'(span + int'($urandom_range(0, 2)));
		if (sel < 92) return 16'(-1 - int'($urandom_range(0, 2)));
		return 16'($urandom);
	endfunction

	function automatic rrfw_pkg::in_item_t random_item(input logic [1:0] rot);
		rrfw_pkg::in_item_t it;
		int pick;
		pick = $urandom_range(0, 999);
		it.color565 = 16'($urandom);
		it.red_in = 8'($urandom);
		it.green_in = 8'($urandom);
		it.blue_in = 8'($urandom);
		if (pick < 12) begin
			// fill ignores the coordinates: drive anything
			it.operation = rrfw_pkg::OP_FILL;
			it.pos_x = 16'($urandom);
			it.pos_y = 16'($urandom);
		end else if (pick < 660) begin
			it.operation = (pick < 360) ? rrfw_pkg::OP_DRAW : rrfw_pkg::OP_SET;
			it.pos_x = pick_coord(rot[0] ? PANEL_H : PANEL_W);
			it.pos_y = pick_coord(rot[0] ? PANEL_W : PANEL_H);
		end else begin
			it.operation = rrfw_pkg::OP_READ;
			it.pos_x = pick_coord(PANEL_W);
			it.pos_y = pick_coord(PANEL_H);
		end
		return it;
	endfunction

	function automatic int pick_gap(input bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one transfer, hold it until taken, then idle for the gap.
	// With no gap, valid stays high and the next call only changes the payload.
	task automatic send(input rrfw_pkg::in_item_t it, input int gap);
		pix_data <= it;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		ops_sent[it.operation]++;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Setup phase, then access phase until pready, then idle with psel low
	task automatic apb_access(input logic write, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= ROT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Drain all results, then let any fill sweep finish before touching the
	// register
	task automatic settle();
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_rotation(input logic [1:0] rot);
		apb_access(1'b1, 32'(rot));
		apb_access(1'b0, 32'd0);
		rot_now = rot;
	endtask

	initial begin : stimulus
		rrfw_pkg::in_item_t opening [$];
		bit burst;
		rot_now = 2'd0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// hold off over the clearing pass, then write the reset value back
		settle();
		set_rotation(2'd0);

		// Opening set under rotation 0: store empty after reset, corners,
		// out-of-range coordinates on every side, fill with colour and with zero
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 0, 0, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, 0, 0, 16'hFFFF, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 0, 0, 16'h0000, 24'hFFFFFF));
		opening.push_back(pixel_op(rrfw_pkg::OP_SET, PANEL_W - 1, PANEL_H - 1, 16'hFFFF,
		                           24'hA55AC3));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, PANEL_W - 1, PANEL_H - 1, 16'h0000,
		                           24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, PANEL_W, 0, 16'h1234, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, 0, PANEL_H, 16'h1234, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_SET, -1, 0, 16'h0000, 24'hFFFFFF));
		opening.push_back(pixel_op(rrfw_pkg::OP_SET, 0, -32768, 16'h0000, 24'h123456));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, 32767, 32767, 16'hFFFF, 24'hFFFFFF));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, -32768, 5, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, PANEL_W, PANEL_H - 1, 16'h0000,
		                           24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, PANEL_W - 1, PANEL_H, 16'h0000,
		                           24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_FILL, -1, 32767, 16'hF800, 24'hFFFFFF));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 10, 10, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, 5, 5, 16'h07E0, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 5, 5, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_FILL, 0, 0, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 5, 5, 16'hFFFF, 24'hFFFFFF));
		opening.push_back(pixel_op(rrfw_pkg::OP_SET, 1, 2, 16'h0000, 24'hFF00FF));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 1, 2, 16'h0000, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_DRAW, 32, 16, 16'h001F, 24'h000000));
		opening.push_back(pixel_op(rrfw_pkg::OP_READ, 32, 16, 16'h0000, 24'h000000));
		foreach (opening[i])
			send(opening[i], $urandom_range(0, 1));
		pix_valid <= 1'b0;

		// Random phases, one rotation each, register changed only when idle
		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_rotation(ROT_PLAN[p]);
			burst = 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// every forty transfers, maybe run a stretch with no gaps
				if (i % 40 == 0)
					burst = ($urandom_range(0, 3) == 0);
				send(random_item(rot_now), pick_gap(burst));
			end
			pix_valid <= 1'b0;
		end

		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);

		$display("Sent %0d draw, %0d set, %0d fill, %0d read transfers; %0d results checked.",
		         ops_sent[rrfw_pkg::OP_DRAW], ops_sent[rrfw_pkg::OP_SET],
		         ops_sent[rrfw_pkg::OP_FILL], ops_sent[rrfw_pkg::OP_READ], checked);
		$display("Rotations 0 to 3 each exercised with clipping on every edge.");
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
